/* design/wcs_pkg.sv */
`default_nettype none

package wcs_pkg;

    localparam int STEP_W = 3;

    typedef logic [STEP_W-1:0] step_t;

    // Program layout; the last step falls through to the first by wrap.
    localparam step_t STEP_ACCEPT = 3'd0;
    localparam step_t STEP_FMUL   = 3'd1;
    localparam step_t STEP_FADD   = 3'd2;
    localparam step_t STEP_SLEW   = 3'd3;
    localparam step_t STEP_SMUL   = 3'd4;
    localparam step_t STEP_SCALE  = 3'd5;
    localparam step_t STEP_NEXT   = 3'd6;
    localparam step_t STEP_DECIDE = 3'd7;

    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_FMUL   = 3'd1,
        OP_FADD   = 3'd2,
        OP_SLEW   = 3'd3,
        OP_SMUL   = 3'd4,
        OP_SCALE  = 3'd5,
        OP_NEXT   = 3'd6,
        OP_DECIDE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_WAIT_IN  = 2'd1,
        COND_WAIT_OUT = 2'd2,
        COND_LOOP     = 2'd3
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic exec;
        logic wheel;
    } ctrl_t;

    typedef struct packed {
        logic [16:0] filter_alpha;
        logic [22:0] max_step;
        logic [22:0] zero_enter;
        logic [22:0] zero_exit;
        logic [23:0] speed_scale;
        logic [7:0]  settle_limit;
        logic [6:0]  left_node;
        logic [6:0]  right_node;
    } cfg_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_ALPHA = 4'd0,
        REG_MAX_STEP     = 4'd1,
        REG_ZERO_ENTER   = 4'd2,
        REG_ZERO_EXIT    = 4'd3,
        REG_SPEED_SCALE  = 4'd4,
        REG_SETTLE_LIMIT = 4'd5,
        REG_LEFT_NODE    = 4'd6,
        REG_RIGHT_NODE   = 4'd7
    } cfg_reg_t;

    localparam logic [16:0] RST_FILTER_ALPHA = 17'd65536;
    localparam logic [22:0] RST_MAX_STEP     = 23'd524288;
    localparam logic [22:0] RST_ZERO_ENTER   = 23'd1311;
    localparam logic [22:0] RST_ZERO_EXIT    = 23'd2621;
    localparam logic [23:0] RST_SPEED_SCALE  = 24'd234716;
    localparam logic [7:0]  RST_SETTLE_LIMIT = 8'd5;
    localparam logic [6:0]  RST_LEFT_NODE    = 7'd1;
    localparam logic [6:0]  RST_RIGHT_NODE   = 7'd2;

    localparam logic signed [23:0] V_MAX      = 24'sh7FFFFF;
    localparam logic signed [23:0] V_MIN      = -24'sh800000;
    localparam logic signed [31:0] T_MAX      = 32'sh7FFFFFFF;
    localparam logic signed [31:0] T_MIN      = -32'sh80000000;
    localparam logic signed [31:0] DEADBAND   = 32'sd100;
    localparam logic [10:0]        FRAME_BASE = 11'h200;
    localparam logic [49:0]        TRUNC_BIAS = 50'd65535;

    function automatic ucode_t ucode(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_ACCEPT: w = '{OP_ACCEPT, COND_WAIT_IN,  STEP_ACCEPT};
            STEP_FMUL:   w = '{OP_FMUL,   COND_NONE,     STEP_ACCEPT};
            STEP_FADD:   w = '{OP_FADD,   COND_NONE,     STEP_ACCEPT};
            STEP_SLEW:   w = '{OP_SLEW,   COND_NONE,     STEP_ACCEPT};
            STEP_SMUL:   w = '{OP_SMUL,   COND_NONE,     STEP_ACCEPT};
            STEP_SCALE:  w = '{OP_SCALE,  COND_NONE,     STEP_ACCEPT};
            STEP_NEXT:   w = '{OP_NEXT,   COND_LOOP,     STEP_FMUL};
            STEP_DECIDE: w = '{OP_DECIDE, COND_WAIT_OUT, STEP_DECIDE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/wcs_sequencer.sv */
`default_nettype none

module wcs_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           out_busy,
    output wcs_pkg::ctrl_t      ctrl,
    output logic                in_ready
);

    wcs_pkg::step_t  step_reg;
    wcs_pkg::step_t  step_next;
    logic            wheel_reg;
    logic            wheel_next;
    wcs_pkg::ucode_t cw;
    logic            hold;
    logic            jump;

    assign cw = wcs_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            wcs_pkg::COND_WAIT_IN:  hold = !in_valid;
            wcs_pkg::COND_WAIT_OUT: hold = out_busy;
            wcs_pkg::COND_NONE,
            wcs_pkg::COND_LOOP:     hold = 1'b0;
        endcase
    end

    // loop back for the second wheel, fall through after it
    assign jump = hold || (cw.cond == wcs_pkg::COND_LOOP && !wheel_reg);
    assign step_next = jump ? cw.target : wcs_pkg::step_t'(step_reg + 1'b1);
    assign wheel_next = (cw.op == wcs_pkg::OP_NEXT) ? ~wheel_reg : wheel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= wcs_pkg::STEP_ACCEPT;
            wheel_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            wheel_reg <= wheel_next;
        end
    end

    assign ctrl.op    = cw.op;
    assign ctrl.exec  = !hold;
    assign ctrl.wheel = wheel_reg;
    assign in_ready   = (cw.op == wcs_pkg::OP_ACCEPT);

`ifndef SYNTHESIS
    a_loop_second_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == wcs_pkg::STEP_NEXT && !wheel_reg)
        |=> (step_reg == wcs_pkg::STEP_FMUL && wheel_reg))
        else $error("second wheel pass not started");

    a_hold_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == wcs_pkg::STEP_DECIDE && out_busy)
        |=> (step_reg == wcs_pkg::STEP_DECIDE))
        else $error("decide step left while output word pending");

    a_accept_first_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == wcs_pkg::STEP_ACCEPT) |-> !wheel_reg)
        else $error("accept step reached with second wheel selected");
`endif

endmodule

`default_nettype wire

/* design/wcs_datapath.sv */
`default_nettype none

module wcs_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wcs_pkg::ctrl_t      ctrl,
    input  wire wcs_pkg::cfg_t       cfg,
    input  wire logic signed [23:0]  left_command,
    input  wire logic signed [23:0]  right_command,
    input  wire logic                out_ready,
    output logic                     out_busy,
    output logic                     out_valid,
    output logic [10:0]              left_frame_id,
    output logic signed [31:0]       left_target,
    output logic [10:0]              right_frame_id,
    output logic signed [31:0]       right_target
);

    logic signed [23:0] cmd_reg [2];
    logic signed [23:0] f_reg [2];
    logic signed [23:0] s_reg [2];
    logic signed [31:0] t_reg [2];
    logic               zl_reg [2];
    logic               seeded_reg;
    logic               idle_reg;
    logic               idle_next;
    logic [7:0]         settle_reg;
    logic [7:0]         settle_next;
    logic signed [49:0] prod_reg;
    logic               out_valid_reg;
    logic [10:0]        left_id_reg;
    logic [10:0]        right_id_reg;
    logic signed [31:0] left_t_reg;
    logic signed [31:0] right_t_reg;

    logic               w;
    logic               run;
    logic signed [23:0] f_cur;
    logic signed [23:0] s_cur;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [49:0] mul_a_ext;
    logic signed [49:0] mul_b_ext;
    logic signed [49:0] mul_p;
    logic [49:0]        prod_bias;
    logic signed [33:0] q;
    logic signed [33:0] fsum;
    logic signed [23:0] f_new;
    logic signed [24:0] diff;
    logic signed [24:0] stp;
    logic signed [24:0] dclamp;
    logic signed [24:0] s1;
    logic [24:0]        mag;
    logic signed [23:0] s_new;
    logic               zl_new;
    logic signed [33:0] tn;
    logic signed [31:0] tc;
    logic signed [31:0] t_new;
    logic               targets_zero;
    logic               send;
    logic [7:0]         cnt_inc;

    assign w     = ctrl.wheel;
    assign run   = ctrl.exec;
    assign f_cur = f_reg[w];
    assign s_cur = s_reg[w];

    // one shared signed multiplier, 25 x 25
    always_comb
    begin
        if (ctrl.op == wcs_pkg::OP_SMUL)
        begin
            mul_a = {s_cur[23], s_cur};
            mul_b = {1'b0, cfg.speed_scale};
        end
        else
        begin
            mul_a = {cmd_reg[w][23], cmd_reg[w]} - {f_cur[23], f_cur};
            mul_b = {8'd0, cfg.filter_alpha};
        end
        mul_a_ext = {{25{mul_a[24]}}, mul_a};
        mul_b_ext = {{25{mul_b[24]}}, mul_b};
        mul_p     = mul_a_ext * mul_b_ext;
    end

    // divide by 65536 rounding toward zero
    assign prod_bias = prod_reg + (prod_reg[49] ? wcs_pkg::TRUNC_BIAS : 50'd0);
    assign q         = prod_bias[49:16];

    always_comb
    begin
        fsum = {{10{f_cur[23]}}, f_cur} + q;
        if (fsum[33:23] == {11{fsum[33]}})
            f_new = fsum[23:0];
        else
            f_new = fsum[33] ? wcs_pkg::V_MIN : wcs_pkg::V_MAX;
    end

    always_comb
    begin
        diff = {f_cur[23], f_cur} - {s_cur[23], s_cur};
        stp  = {2'b00, cfg.max_step};
        if (diff > stp)
            dclamp = stp;
        else if (diff < -stp)
            dclamp = -stp;
        else
            dclamp = diff;
        s1  = {s_cur[23], s_cur} + dclamp;
        mag = s1[24] ? 25'(-s1) : 25'(s1);
        zl_new = zl_reg[w];
        s_new  = s1[23:0];
        if (zl_reg[w])
        begin
            if (mag > {2'b00, cfg.zero_exit})
                zl_new = 1'b0;
            else
                s_new = 24'sd0;
        end
        else if (mag < {2'b00, cfg.zero_enter})
        begin
            zl_new = 1'b1;
            s_new  = 24'sd0;
        end
    end

    always_comb
    begin
        tn = w ? -q : q;
        if (tn[33:31] == {3{tn[33]}})
            tc = tn[31:0];
        else
            tc = tn[33] ? wcs_pkg::T_MIN : wcs_pkg::T_MAX;
        if (tc > -wcs_pkg::DEADBAND && tc < wcs_pkg::DEADBAND)
            t_new = 32'sd0;
        else
            t_new = tc;
    end

    // settle / idle bookkeeping for the finished tick
    always_comb
    begin
        targets_zero = (t_reg[0] == 32'sd0) && (t_reg[1] == 32'sd0);
        idle_next    = idle_reg;
        settle_next  = settle_reg;
        send         = 1'b0;
        cnt_inc      = (settle_reg == 8'hFF) ? settle_reg : settle_reg + 8'd1;
        priority if (idle_reg && targets_zero)
        begin
            send = 1'b0;
        end
        else if (targets_zero)
        begin
            settle_next = cnt_inc;
            send        = (cnt_inc <= cfg.settle_limit);
            idle_next   = (cnt_inc >= cfg.settle_limit);
        end
        else
        begin
            settle_next = 8'd0;
            idle_next   = 1'b0;
            send        = 1'b1;
        end
    end

    assign out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            idle_reg      <= 1'b0;
            settle_reg    <= 8'd0;
            zl_reg[0]     <= 1'b1;
            zl_reg[1]     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == wcs_pkg::OP_ACCEPT && run)
                seeded_reg <= 1'b1;
            if (ctrl.op == wcs_pkg::OP_SLEW)
                zl_reg[w] <= zl_new;
            if (ctrl.op == wcs_pkg::OP_DECIDE && run)
            begin
                idle_reg   <= idle_next;
                settle_reg <= settle_next;
            end
            if (ctrl.op == wcs_pkg::OP_DECIDE && run && send)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            wcs_pkg::OP_ACCEPT:
            begin
                if (run)
                begin
                    cmd_reg[0] <= left_command;
                    cmd_reg[1] <= right_command;
                    if (!seeded_reg)
                    begin
                        f_reg[0] <= left_command;
                        f_reg[1] <= right_command;
                        s_reg[0] <= left_command;
                        s_reg[1] <= right_command;
                    end
                end
            end
            wcs_pkg::OP_FMUL,
            wcs_pkg::OP_SMUL:
                prod_reg <= mul_p;
            wcs_pkg::OP_FADD:
                f_reg[w] <= f_new;
            wcs_pkg::OP_SLEW:
                s_reg[w] <= s_new;
            wcs_pkg::OP_SCALE:
                t_reg[w] <= t_new;
            wcs_pkg::OP_DECIDE:
            begin
                if (run && send)
                begin
                    left_id_reg  <= wcs_pkg::FRAME_BASE + {4'd0, cfg.left_node};
                    right_id_reg <= wcs_pkg::FRAME_BASE + {4'd0, cfg.right_node};
                    left_t_reg   <= t_reg[0];
                    right_t_reg  <= t_reg[1];
                end
            end
            wcs_pkg::OP_NEXT:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign left_frame_id  = left_id_reg;
    assign right_frame_id = right_id_reg;
    assign left_target    = left_t_reg;
    assign right_target   = right_t_reg;

`ifndef SYNTHESIS
    a_seeded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((left_t_reg == 32'sd0 || left_t_reg >= wcs_pkg::DEADBAND
            || left_t_reg <= -wcs_pkg::DEADBAND)
            && (right_t_reg == 32'sd0 || right_t_reg >= wcs_pkg::DEADBAND
            || right_t_reg <= -wcs_pkg::DEADBAND)))
        else $error("target inside deadband");

    a_latch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == wcs_pkg::OP_SLEW && !ctrl.wheel)
        |=> (!zl_reg[0] || s_reg[0] == 24'sd0))
        else $error("latched wheel holds nonzero shaped value");
`endif

endmodule

`default_nettype wire

/* design/wheel_command_shaper.sv */
`default_nettype none

// Shapes left/right wheel velocity commands (Q7.16 rad/s) once per control
// tick: low-pass filter, slew limit, zero latch with hysteresis, scaling to
// drive units (right wheel negated) and a deadband of 100. At most one
// output word per input word; while both wheels stay zero, up to
// settle_limit zero words go out before the block falls silent until a
// nonzero target results. A small microcode program steps one shared
// 25x25 multiplier through both wheels: an input word passes an accept
// step, six steps per wheel and one decide step, and the next word is
// taken at the earliest in the cycle after the decide step, so no new word
// is taken before the last one is through. The decide step waits only if
// the previous output word has not yet been taken. Configuration writes
// are always ready and must be issued while no tick is in flight.
module wheel_command_shaper (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [23:0]                  left_command,
    input  wire logic signed [23:0]                  right_command,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [10:0]                              left_frame_id,
    output logic signed [31:0]                       left_target,
    output logic [10:0]                              right_frame_id,
    output logic signed [31:0]                       right_target,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [wcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    wcs_pkg::cfg_t  cfg_reg;
    wcs_pkg::ctrl_t ctrl;
    logic           out_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha <= wcs_pkg::RST_FILTER_ALPHA;
            cfg_reg.max_step     <= wcs_pkg::RST_MAX_STEP;
            cfg_reg.zero_enter   <= wcs_pkg::RST_ZERO_ENTER;
            cfg_reg.zero_exit    <= wcs_pkg::RST_ZERO_EXIT;
            cfg_reg.speed_scale  <= wcs_pkg::RST_SPEED_SCALE;
            cfg_reg.settle_limit <= wcs_pkg::RST_SETTLE_LIMIT;
            cfg_reg.left_node    <= wcs_pkg::RST_LEFT_NODE;
            cfg_reg.right_node   <= wcs_pkg::RST_RIGHT_NODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unlisted indexes are dropped
            unique case (cfg_index)
                wcs_pkg::REG_FILTER_ALPHA: cfg_reg.filter_alpha <= cfg_data[16:0];
                wcs_pkg::REG_MAX_STEP:     cfg_reg.max_step     <= cfg_data[22:0];
                wcs_pkg::REG_ZERO_ENTER:   cfg_reg.zero_enter   <= cfg_data[22:0];
                wcs_pkg::REG_ZERO_EXIT:    cfg_reg.zero_exit    <= cfg_data[22:0];
                wcs_pkg::REG_SPEED_SCALE:  cfg_reg.speed_scale  <= cfg_data[23:0];
                wcs_pkg::REG_SETTLE_LIMIT: cfg_reg.settle_limit <= cfg_data[7:0];
                wcs_pkg::REG_LEFT_NODE:    cfg_reg.left_node    <= cfg_data[6:0];
                wcs_pkg::REG_RIGHT_NODE:   cfg_reg.right_node   <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    wcs_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    wcs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .left_command   (left_command),
        .right_command  (right_command),
        .out_ready      (out_ready),
        .out_busy       (out_busy),
        .out_valid      (out_valid),
        .left_frame_id  (left_frame_id),
        .left_target    (left_target),
        .right_frame_id (right_frame_id),
        .right_target   (right_target)
    );

endmodule

`default_nettype wire

/* dv/wheel_command_shaper_tb.sv */
module wheel_command_shaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcs_pkg::*;

    localparam longint Q_ONE = 65536;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_MAX = 10;
    localparam int ITEMS_PER_SETTING = 110;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd15;

    localparam int STYLE_MIXED = 0;
    localparam int STYLE_HIGH  = 1;
    localparam int STYLE_LOW   = 2;

    typedef struct packed {
        logic [10:0] left_id;
        logic [31:0] left_target;
        logic [10:0] right_id;
        logic [31:0] right_target;
    } frame_t;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic signed [23:0]     left_cmd;
        logic signed [23:0]     right_cmd;
        bit                     typed;
        frame_t                 want;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [23:0]            left_command;
    logic signed [23:0]            right_command;
    logic                          out_valid;
    logic                          out_ready;
    logic [10:0]                   left_frame_id;
    logic signed [31:0]            left_target;
    logic [10:0]                   right_frame_id;
    logic signed [31:0]            right_target;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    // shadow of the block: configuration and per-wheel shaping state
    cfg_t shadow_cfg = '{
        filter_alpha: RST_FILTER_ALPHA, max_step: RST_MAX_STEP,
        zero_enter: RST_ZERO_ENTER, zero_exit: RST_ZERO_EXIT,
        speed_scale: RST_SPEED_SCALE, settle_limit: RST_SETTLE_LIMIT,
        left_node: RST_LEFT_NODE, right_node: RST_RIGHT_NODE};
    longint lp_state[2]   = '{0, 0};
    longint slew_state[2] = '{0, 0};
    bit     held_zero[2]  = '{1'b1, 1'b1};
    bit     primed        = 1'b0;
    bit     asleep        = 1'b0;
    int     zero_ticks    = 0;

    frame_t pending_frames[$];
    row_t   plan[$];
    int     mismatch_count = 0;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_len = 0;

    wheel_command_shaper uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_command   (left_command),
        .right_command  (right_command),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_frame_id  (left_frame_id),
        .left_target    (left_target),
        .right_frame_id (right_frame_id),
        .right_target   (right_target),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint filter_slew_latch(input int w, input longint cmd);
        longint f;
        longint s;
        longint lim;
        longint mag;
        f = lp_state[w];
        s = slew_state[w];
        lim = longint'(shadow_cfg.max_step);
        f = clamp(f + (longint'(shadow_cfg.filter_alpha) * (cmd - f)) / Q_ONE,
                  longint'(V_MIN), longint'(V_MAX));
        s = s + clamp(f - s, -lim, lim);
        mag = (s < 0) ? -s : s;
        if (held_zero[w])
        begin
            if (mag > longint'(shadow_cfg.zero_exit))
                held_zero[w] = 1'b0;
            else
                s = 0;
        end
        else if (mag < longint'(shadow_cfg.zero_enter))
        begin
            held_zero[w] = 1'b1;
            s = 0;
        end
        lp_state[w] = f;
        slew_state[w] = s;
        return s;
    endfunction

    function automatic longint scale_target(input longint s, input bit invert);
        longint t;
        t = (s * longint'(shadow_cfg.speed_scale)) / Q_ONE;
        if (invert)
            t = -t;
        t = clamp(t, longint'(T_MIN), longint'(T_MAX));
        if (t > -longint'(DEADBAND) && t < longint'(DEADBAND))
            t = 0;
        return t;
    endfunction

    // returns 1 when this tick sends a word
    function automatic bit next_frame(input logic signed [23:0] lc, input logic signed [23:0] rc,
                                      output frame_t fr);
        longint tl;
        longint tr;
        if (!primed)
        begin
            lp_state[0] = longint'(lc);
            slew_state[0] = longint'(lc);
            lp_state[1] = longint'(rc);
            slew_state[1] = longint'(rc);
            primed = 1'b1;
        end
        tl = scale_target(filter_slew_latch(0, longint'(lc)), 1'b0);
        tr = scale_target(filter_slew_latch(1, longint'(rc)), 1'b1);
        fr = '{FRAME_BASE + 11'(shadow_cfg.left_node), 32'(tl),
               FRAME_BASE + 11'(shadow_cfg.right_node), 32'(tr)};
        if (asleep)
        begin
            if (tl == 0 && tr == 0)
                return 1'b0;
            asleep = 1'b0;
            zero_ticks = 0;
        end
        if (tl == 0 && tr == 0)
        begin
            if (zero_ticks < 255)
                zero_ticks++;
            if (zero_ticks >= int'(shadow_cfg.settle_limit))
                asleep = 1'b1;
            return zero_ticks <= int'(shadow_cfg.settle_limit);
        end
        zero_ticks = 0;
        return 1'b1;
    endfunction

    function automatic void add_tick(input logic signed [23:0] lc, input logic signed [23:0] rc,
                                     input bit typed, input frame_t want);
        row_t r;
        r.kind = ROW_TICK;
        r.index = '0;
        r.data = '0;
        r.left_cmd = lc;
        r.right_cmd = rc;
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        row_t r;
        r.kind = ROW_WRITE;
        r.index = idx;
        r.data = d;
        r.left_cmd = '0;
        r.right_cmd = '0;
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic logic signed [23:0] moderate_cmd();
        if ($urandom_range(9, 0) < 3)
            return 24'($urandom);
        return 24'(int'($urandom_range(2097152, 0)) - 1048576);
    endfunction

    function automatic logic signed [23:0] near_zero_cmd();
        int m;
        m = $urandom_range(2 * int'(shadow_cfg.zero_exit) + 2, 0);
        return 24'($urandom_range(1, 0) ? -m : m);
    endfunction

    function automatic cfg_t pick_setting(input int style);
        cfg_t c;
        c.filter_alpha = 17'($urandom_range(65536, 2048));
        if ($urandom_range(3, 0) == 0)
            c.filter_alpha = 17'($urandom_range(131071, 65536));
        c.max_step = 23'($urandom_range(1 << 20, 512));
        c.zero_enter = 23'($urandom_range(20000, 0));
        c.zero_exit = 23'(c.zero_enter + $urandom_range(20000, 0));
        c.speed_scale = 24'($urandom_range(400000, 500));
        c.settle_limit = 8'($urandom_range(10, 0));
        c.left_node = 7'($urandom_range(127, 1));
        c.right_node = 7'($urandom_range(127, 1));
        if ($urandom_range(7, 0) == 0)
            c.max_step = '1;
        if ($urandom_range(7, 0) == 0)
            c.speed_scale = '1;
        if ($urandom_range(7, 0) == 0)
            c.settle_limit = '0;
        if ($urandom_range(7, 0) == 0)
            c.zero_exit = '0;
        if (style == STYLE_HIGH)
            c = '1;
        else if (style == STYLE_LOW)
            c = '0;
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_FILTER_ALPHA: shadow_cfg.filter_alpha = d[16:0];
            REG_MAX_STEP:     shadow_cfg.max_step     = d[22:0];
            REG_ZERO_ENTER:   shadow_cfg.zero_enter   = d[22:0];
            REG_ZERO_EXIT:    shadow_cfg.zero_exit    = d[22:0];
            REG_SPEED_SCALE:  shadow_cfg.speed_scale  = d[23:0];
            REG_SETTLE_LIMIT: shadow_cfg.settle_limit = d[7:0];
            REG_LEFT_NODE:    shadow_cfg.left_node    = d[6:0];
            REG_RIGHT_NODE:   shadow_cfg.right_node   = d[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // upper data bits carry junk to exercise the width masking
    task automatic apply_setting(input cfg_t c);
        logic [23:0] junk;
        logic [CFG_INDEX_W-1:0] bad;
        junk = 24'($urandom);
        bad = 4'($urandom_range(REG_UNMAPPED, REG_RIGHT_NODE + 1));
        write_reg(bad, 24'($urandom));
        write_reg(REG_FILTER_ALPHA, {junk[23:17], c.filter_alpha});
        write_reg(REG_MAX_STEP, {junk[23], c.max_step});
        write_reg(REG_ZERO_ENTER, {junk[23], c.zero_enter});
        write_reg(REG_ZERO_EXIT, {junk[23], c.zero_exit});
        write_reg(REG_SPEED_SCALE, c.speed_scale);
        write_reg(REG_SETTLE_LIMIT, {junk[23:8], c.settle_limit});
        write_reg(REG_LEFT_NODE, {junk[23:7], c.left_node});
        write_reg(REG_RIGHT_NODE, {junk[23:7], c.right_node});
    endtask

    task automatic send_tick(input logic signed [23:0] lc, input logic signed [23:0] rc,
                             input bit typed, input frame_t want);
        frame_t fr;
        bit has;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_command <= lc;
        right_command <= rc;
        do @(posedge clk); while (!(in_valid && in_ready));
        has = next_frame(lc, rc, fr);
        if (typed)
            pending_frames.push_back(want);
        else if (has)
            pending_frames.push_back(fr);
        @(negedge clk);
    endtask

    // an idle tick leaves no word behind, so give the block time past the last one
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic run_segment(output int n);
        int kind;
        int len;
        logic signed [23:0] a;
        logic signed [23:0] b;
        kind = $urandom_range(9, 0);
        len = $urandom_range(12, 1);
        a = moderate_cmd();
        b = moderate_cmd();
        if (kind == 5 || kind == 6)
        begin
            // stop: zero run of up to settle_limit + 3 ticks, which can reach the settle limit
            len = $urandom_range(int'(shadow_cfg.settle_limit) + 3, 1);
            if (len > 40 && $urandom_range(3, 0) != 0)
                len = $urandom_range(40, 1);
            a = '0;
            b = '0;
        end
        else if (kind == 8)
        begin
            if ($urandom_range(1, 0))
                a = '0;
            else
                b = '0;
        end
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                4: send_tick(24'(a + (int'($urandom_range(4000, 0)) - 2000)),
                             24'(b + (int'($urandom_range(4000, 0)) - 2000)), 1'b0, '0);
                7: send_tick(near_zero_cmd(), near_zero_cmd(), 1'b0, '0);
                9: send_tick(24'($urandom), 24'($urandom), 1'b0, '0);
                default: send_tick(a, b, 1'b0, '0);
            endcase
        end
        n = len;
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(negedge clk);
                hold_off_len = 0;
            end
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_words
        frame_t got;
        frame_t exp_fr;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{left_frame_id, left_target, right_frame_id, right_target};
            if (pending_frames.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected word: %h %0d %h %0d", got.left_id,
                             $signed(got.left_target), got.right_id,
                             $signed(got.right_target));
                mismatch_count++;
            end
            else
            begin
                exp_fr = pending_frames.pop_front();
                if (got !== exp_fr)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("mismatch: exp %h %0d %h %0d, got %h %0d %h %0d",
                                 exp_fr.left_id, $signed(exp_fr.left_target),
                                 exp_fr.right_id, $signed(exp_fr.right_target),
                                 got.left_id, $signed(got.left_target),
                                 got.right_id, $signed(got.right_target));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int n;
        int style;
        bit after_tick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        left_command = '0;
        right_command = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 31;
        recv_idle_pct = 62;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: first tick seeds filter and slew with the command
        add_tick(24'sd131072, -24'sd131072, 1'b1,
                 frame_t'{FRAME_BASE + 11'd1, 32'd469432, FRAME_BASE + 11'd2, 32'd469432});
        add_tick(V_MAX, V_MIN, 1'b1,
                 frame_t'{FRAME_BASE + 11'd1, 32'd2347160, FRAME_BASE + 11'd2, 32'd2347160});
        add_tick(V_MAX, V_MIN, 1'b0, '0);
        repeat (6) add_tick('0, '0, 1'b0, '0);
        add_tick(24'sd1000, -24'sd1000, 1'b0, '0);
        add_tick('0, '0, 1'b0, '0);
        add_tick(24'sd200000, '0, 1'b0, '0);
        // gain above one, no limits, no settle frames, node out of range
        add_write(REG_FILTER_ALPHA, 24'hFFFFFF);
        add_write(REG_MAX_STEP, 24'hFFFFFF);
        add_write(REG_ZERO_ENTER, '0);
        add_write(REG_ZERO_EXIT, '0);
        add_write(REG_SPEED_SCALE, 24'hFFFFFF);
        add_write(REG_SETTLE_LIMIT, '0);
        add_write(REG_LEFT_NODE, '0);
        add_write(REG_RIGHT_NODE, 24'hFFFFFF);
        add_write(REG_UNMAPPED, 24'hFFFFFF);
        add_tick(V_MAX, V_MAX, 1'b0, '0);
        add_tick(V_MIN, V_MIN, 1'b0, '0);
        add_tick(V_MAX, V_MIN, 1'b0, '0);
        repeat (3) add_tick('0, '0, 1'b0, '0);
        add_tick(-24'sd1, 24'sd1, 1'b0, '0);
        // frozen filter, widest latch, longest settle
        add_write(REG_FILTER_ALPHA, '0);
        add_write(REG_ZERO_ENTER, 24'h7FFFFF);
        add_write(REG_ZERO_EXIT, 24'h7FFFFF);
        add_write(REG_SPEED_SCALE, 24'd1);
        add_write(REG_SETTLE_LIMIT, 24'hFF);
        add_tick(24'sd12345, -24'sd12345, 1'b0, '0);
        add_tick(24'sd12345, -24'sd12345, 1'b0, '0);
        add_tick('0, '0, 1'b0, '0);

        after_tick = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (after_tick)
                    wait_quiet();
                after_tick = 1'b0;
                write_reg(plan[i].index, plan[i].data);
            end
            else
            begin
                send_tick(plan[i].left_cmd, plan[i].right_cmd, plan[i].typed, plan[i].want);
                after_tick = 1'b1;
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : ((phase == 1) ? 62 : 0);
            recv_idle_pct = (phase == 0) ? 62 : ((phase == 1) ? 31 : 0);
            for (int blk = 0; blk < 5; blk++)
            begin
                style = STYLE_MIXED;
                if (phase == 0 && blk == 4)
                    style = STYLE_HIGH;
                else if (phase == 1 && blk == 4)
                    style = STYLE_LOW;
                wait_quiet();
                apply_setting(pick_setting(style));
                // long receiver stall while ticks keep coming: output fills, input stalls
                if (blk == 2)
                    hold_off_len = $urandom_range(400, 250);
                sent = 0;
                while (sent < ITEMS_PER_SETTING)
                begin
                    run_segment(n);
                    sent += n;
                end
            end
        end

        wait_quiet();
        if (mismatch_count == 0 && pending_frames.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
